/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Transaction types, action codes, register indexes and sequencer phases
// shared by the byte engine modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_STOP  = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_WAIT  = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;
   localparam logic [2:0] ACT_TICK  = 3'd5;

   localparam logic [1:0] CSR_ACK_POLL_LIMIT = 2'd0;
   localparam logic [1:0] CSR_HOLD_TICKS     = 2'd1;
   localparam logic [1:0] CSR_HALF_TICKS     = 2'd2;

   localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;
   localparam logic [3:0] HOLD_TICKS_RST     = 4'd4;
   localparam logic [3:0] HALF_TICKS_RST     = 4'd2;
   localparam logic [7:0] POLL_MAX           = 8'hFF;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_A    = 5'd1,
      PH_ST_B    = 5'd2,
      PH_SP_A    = 5'd3,
      PH_SP_B    = 5'd4,
      PH_SP_C    = 5'd5,
      PH_WR_LO   = 5'd6,
      PH_WR_HI   = 5'd7,
      PH_AK_LO   = 5'd8,
      PH_AK_POLL = 5'd9,
      PH_RD_LO   = 5'd10,
      PH_RD_HI   = 5'd11,
      PH_RA_LO   = 5'd12,
      PH_RA_HI   = 5'd13
   } phase_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_byte;
      logic       ack_after_read;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_timeout;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ack_poll_limit;
      logic [3:0] hold_ticks;
      logic [3:0] half_ticks;
   } cfg_type;

endpackage

/* rtl/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Bus phase state machine: takes one registered transaction per enabled
// cycle, updates the line, shift and count state and forms its response.
// ----------------------------------------------------------------------------
module i2cm_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [3:0] delay_count_ff, delay_count_in;
   logic [7:0] poll_count_ff, poll_count_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [7:0] last_read_ff, last_read_in;
   logic       timeout_ff, timeout_in;

   logic       done;
   logic       rej;
   logic       fin;
   logic [3:0] hold_lim;
   logic [3:0] half_lim;
   logic [7:0] poll_lim;
   logic [3:0] lim;
   logic [3:0] delay_inc;
   logic       hit;
   logic [7:0] poll_sat;

   assign hold_lim  = (cfg.hold_ticks == 4'd0) ? 4'd1 : cfg.hold_ticks;
   assign half_lim  = (cfg.half_ticks == 4'd0) ? 4'd1 : cfg.half_ticks;
   assign poll_lim  = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
   assign lim       = (phase_ff inside {PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C})
                      ? hold_lim : half_lim;
   assign delay_inc = delay_count_ff + 4'd1;
   assign hit       = (delay_inc >= lim);
   assign poll_sat  = (poll_count_ff < POLL_MAX) ? poll_count_ff + 8'd1 : poll_count_ff;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      delay_count_in = delay_count_ff;
      poll_count_in  = poll_count_ff;
      ack_choice_in  = ack_choice_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      last_read_in   = last_read_ff;
      timeout_in     = timeout_ff;
      done           = 1'b0;
      rej            = 1'b0;
      fin            = 1'b0;
      if (req.action inside {[ACT_START:ACT_READ]}) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            timeout_in     = 1'b0;
            delay_count_in = 4'd0;
            bit_index_in   = 3'd0;
            case (req.action)
               ACT_START: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_ST_A;
               end
               ACT_STOP: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = PH_SP_A;
               end
               ACT_WRITE: begin
                  shift_byte_in = req.data_byte;
                  scl_in        = 1'b0;
                  sda_in        = req.data_byte[7];
                  phase_in      = PH_WR_LO;
               end
               ACT_WAIT: begin
                  scl_in        = 1'b0;
                  sda_in        = 1'b1;
                  poll_count_in = 8'd0;
                  phase_in      = PH_AK_LO;
               end
               default: begin
                  ack_choice_in = req.ack_after_read;
                  shift_byte_in = 8'd0;
                  scl_in        = 1'b0;
                  sda_in        = 1'b1;
                  phase_in      = PH_RD_LO;
               end
            endcase
         end
      end else if (req.action == ACT_TICK && phase_ff != PH_IDLE) begin
         if (phase_ff != PH_AK_POLL) begin
            delay_count_in = hit ? 4'd0 : delay_inc;
         end
         case (phase_ff)
            PH_ST_A: begin
               if (hit) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_ST_B;
               end
            end
            PH_ST_B: begin
               if (hit) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            PH_SP_A: begin
               if (hit) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_SP_B;
               end
            end
            PH_SP_B: begin
               if (hit) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_SP_C;
               end
            end
            PH_SP_C: begin
               fin = hit;
            end
            PH_WR_LO, PH_RD_LO, PH_RA_LO: begin
               if (hit) begin
                  scl_in   = 1'b1;
                  phase_in = (phase_ff == PH_WR_LO) ? PH_WR_HI :
                             (phase_ff == PH_RD_LO) ? PH_RD_HI : PH_RA_HI;
               end
            end
            PH_WR_HI: begin
               if (hit) begin
                  scl_in = 1'b0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = 3'd0;
                     fin          = 1'b1;
                  end else begin
                     bit_index_in  = bit_index_ff + 3'd1;
                     shift_byte_in = {shift_byte_ff[6:0], 1'b0};
                     sda_in        = shift_byte_ff[6];
                     phase_in      = PH_WR_LO;
                  end
               end
            end
            PH_AK_LO: begin
               if (hit) begin
                  scl_in        = 1'b1;
                  poll_count_in = 8'd0;
                  phase_in      = PH_AK_POLL;
               end
            end
            PH_AK_POLL: begin
               if (!req.sda_level) begin
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end else begin
                  poll_count_in = poll_sat;
                  if (poll_sat >= poll_lim) begin
                     timeout_in     = 1'b1;
                     scl_in         = 1'b0;
                     sda_in         = 1'b0;
                     delay_count_in = 4'd0;
                     phase_in       = PH_SP_A;
                  end
               end
            end
            PH_RD_HI: begin
               if (hit) begin
                  shift_byte_in = {shift_byte_ff[6:0], req.sda_level};
                  scl_in        = 1'b0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = 3'd0;
                     sda_in       = ~ack_choice_ff;
                     phase_in     = PH_RA_LO;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     sda_in       = 1'b1;
                     phase_in     = PH_RD_LO;
                  end
               end
            end
            PH_RA_HI: begin
               if (hit) begin
                  scl_in       = 1'b0;
                  last_read_in = shift_byte_ff;
                  fin          = 1'b1;
               end
            end
            default: begin
               fin = 1'b0;
            end
         endcase
         if (fin) begin
            phase_in       = PH_IDLE;
            delay_count_in = 4'd0;
            done           = 1'b1;
         end
      end
   end

   // response
   always_comb begin
      rsp.scl_release = scl_in;
      rsp.sda_release = sda_in;
      rsp.busy_res    = (phase_in != PH_IDLE);
      rsp.done_res    = done;
      rsp.read_data   = last_read_in;
      rsp.ack_timeout = timeout_in;
      rsp.rejected    = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= 3'd0;
         shift_byte_ff  <= 8'd0;
         delay_count_ff <= 4'd0;
         poll_count_ff  <= 8'd0;
         ack_choice_ff  <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         last_read_ff   <= 8'd0;
         timeout_ff     <= 1'b0;
      end else if (enable) begin
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         delay_count_ff <= delay_count_in;
         poll_count_ff  <= poll_count_in;
         ack_choice_ff  <= ack_choice_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         last_read_ff   <= last_read_in;
         timeout_ff     <= timeout_in;
      end
   end

endmodule

/* rtl/i2c_master_byte_engine_top.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Command and tick sequencer driving open-drain SCL and SDA for one master.
//
// The req channel carries one transaction per command or tick; each yields
// exactly one rsp transaction with the line drive levels, busy, done, the
// last read byte, the ack timeout flag and a reject flag for commands that
// arrive while busy. Ticks advance time and carry the sampled SDA level.
// A transaction is registered on entry, evaluated by the sequencer and
// registered again on exit on its way to rsp, and one transaction is taken
// every cycle while rsp is not stalled.
// A stall on rsp holds the output register; the input register still takes
// one more transaction, after which req_stall rises until rsp moves.
// Synchronous reset empties both registers, puts the lines released high,
// clears all sequencer state and loads the register defaults (poll limit
// 250, hold 4 ticks, half bit 2 ticks). The csr port writes a register and
// is to be used only while no transaction is outstanding (not enforced).
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import i2cm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   cfg_type cfg_ff;
   rsp_type seq_rsp;
   logic    fire;
   logic    req_take;

   assign fire        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   i2cm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .enable (fire),
      .req    (in_item_ff),
      .cfg    (cfg_ff),
      .rsp    (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (fire) begin
         out_item_ff <= seq_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_poll_limit <= ACK_POLL_LIMIT_RST;
         cfg_ff.hold_ticks     <= HOLD_TICKS_RST;
         cfg_ff.half_ticks     <= HALF_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACK_POLL_LIMIT: cfg_ff.ack_poll_limit <= csr_wdata;
            CSR_HOLD_TICKS:     cfg_ff.hold_ticks     <= csr_wdata[3:0];
            CSR_HALF_TICKS:     cfg_ff.half_ticks     <= csr_wdata[3:0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   a_done_not_rejected : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.rejected))
      else $error("done and rejected on one transaction");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done while still busy");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("req stalled with empty input register");

   a_fire_loads_output : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("evaluated transaction lost");

endmodule
